FILE: hw/rtl/vfh_pkg.sv
// ----------------------------------------------------------------------------
// vfh_pkg
// Shared types and constants for the verdict feedback history block.
// ----------------------------------------------------------------------------
package vfh_pkg;

	localparam int DEPTH = 1024;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = AW + 1;

	localparam logic [2:0] ACT_RECORD   = 3'd0;
	localparam logic [2:0] ACT_MARK     = 3'd1;
	localparam logic [2:0] ACT_MISSED   = 3'd2;
	localparam logic [2:0] ACT_FALSEBLK = 3'd3;
	localparam logic [2:0] ACT_EVAL     = 3'd4;

	localparam logic [2:0] OC_UNKNOWN = 3'd0;
	localparam logic [2:0] OC_TP      = 3'd1;
	localparam logic [2:0] OC_TN      = 3'd2;
	localparam logic [2:0] OC_FP      = 3'd3;
	localparam logic [2:0] OC_FN      = 3'd4;

	localparam logic [1:0] REG_WINDOW = 2'd0;
	localparam logic [1:0] REG_FBLIM  = 2'd1;
	localparam logic [1:0] REG_MALIM  = 2'd2;
	localparam logic [1:0] REG_STEP   = 2'd3;

	localparam logic [1:0] ADJ_NONE  = 2'd0;
	localparam logic [1:0] ADJ_OK    = 2'd1;
	localparam logic [1:0] ADJ_RAISE = 2'd2;
	localparam logic [1:0] ADJ_LOWER = 2'd3;

	localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
	localparam logic [CW-1:0] MIN_CLASSIFIED = CW'(20);

	typedef struct packed {
		logic [CW-1:0] recs;
		logic [CW-1:0] tp;
		logic [CW-1:0] tn;
		logic [CW-1:0] fp;
		logic [CW-1:0] fn;
	} counts_t;

endpackage

FILE: hw/rtl/vfh_store.sv
// ----------------------------------------------------------------------------
// vfh_store
// Entry memory of the history ring: one write port, one registered read port.
// ----------------------------------------------------------------------------
module vfh_store (
	input  logic                     clk,
	input  logic                     we,
	input  logic [vfh_pkg::AW-1:0]   waddr,
	input  logic [100:0]             wdata,
	input  logic [vfh_pkg::AW-1:0]   raddr,
	output logic [100:0]             rdata
);

	logic [100:0] mem [vfh_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/verdict_feedback_history_core.sv
// ----------------------------------------------------------------------------
// verdict_feedback_history_core
// Ring history of verdicts with outcome marking, detection and evaluation.
// ----------------------------------------------------------------------------
// Record writes its entry in ST_CUT and passes through ST_DONE to ST_OUT,
// where its result is loaded. Mark, detect and evaluate walk the stored
// entries newest first through the single read port of the entry memory,
// each entry passing ST_READ and then ST_CHECK (read, then compare and
// optional write-back), and then pass through ST_RATE and ST_DONE to ST_OUT.
// At most fill_level entries are visited, fewer when a mark hits or a walk
// leaves the window; a detect whose score is out of range, an unused action
// or any walk on an empty ring visits none. The input is not ready while a
// request is in work and is ready again once the result is loaded. A result
// still waiting in the output register holds the next one back until it is
// taken.
module verdict_feedback_history_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [119:0]  s_tdata,  // action, source_address, verdict, outcome, score, time_ns
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [119:0]  m_tdata,  // status, marked_count, window_records, true_pos_count,
	                                // true_neg_count, false_pos_count, false_neg_count,
	                                // adjust_code, delta_allow, delta_rate, drop_step
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [15:0]   cfg_data
);

	localparam int AW = vfh_pkg::AW;
	localparam int CW = vfh_pkg::CW;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CUT   = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_CHECK = 3'd3;
	localparam logic [2:0] ST_RATE  = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;
	localparam logic [2:0] ST_OUT   = 3'd6;

	logic [2:0]    state_q;
	logic [15:0]   window_q, fblim_q, malim_q, step_q;
	logic [2:0]    act_q;
	logic [31:0]   addr_q;
	logic [1:0]    verd_q;
	logic [2:0]    oc_q;
	logic          run_q;
	logic [63:0]   now_q, cut_q;
	logic [AW-1:0] wp_q, slot_q;
	logic [CW-1:0] fill_q, idx_q, marked_q;
	vfh_pkg::counts_t cnt_q;
	logic          status_q;
	logic [47:0]   prod_fp_q, prod_fn_q;
	logic          out_valid_q;
	logic [119:0]  out_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [100:0]  mem_wdata, mem_rdata;

	vfh_store u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (slot_q),
		.rdata (mem_rdata)
	);

	logic [31:0] e_addr;
	logic [63:0] e_time;
	logic [1:0]  e_verd;
	logic [2:0]  e_oc;
	assign e_addr = mem_rdata[31:0];
	assign e_time = mem_rdata[95:32];
	assign e_verd = mem_rdata[97:96];
	assign e_oc   = mem_rdata[100:98];

	logic in_window, hit_mark, hit_det, want_allow;
	assign in_window  = e_time >= cut_q;
	assign hit_mark   = (e_addr == addr_q) && (e_time == now_q);
	assign want_allow = act_q == vfh_pkg::ACT_MISSED;
	assign hit_det    = (e_addr == addr_q) && ((e_verd == 2'd0) == want_allow)
		&& (e_oc == vfh_pkg::OC_UNKNOWN);

	logic [CW-1:0] classified;
	assign classified = cnt_q.tp + cnt_q.tn + cnt_q.fp + cnt_q.fn;

	logic [19:0] score_x10;
	assign score_x10 = {4'd0, s_tdata[55:40]} * 20'd10;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = slot_q;
		mem_wdata = {oc_q, verd_q, now_q, addr_q};
		case (state_q)
			ST_CUT: begin
				if (act_q == vfh_pkg::ACT_RECORD) begin
					mem_we    = 1'b1;
					mem_waddr = wp_q;
					mem_wdata = {vfh_pkg::OC_UNKNOWN, verd_q, now_q, addr_q};
				end
			end
			ST_CHECK: begin
				if (act_q == vfh_pkg::ACT_MARK && hit_mark) begin
					mem_we    = 1'b1;
					mem_wdata = {oc_q, e_verd, e_time, e_addr};
				end else if ((act_q == vfh_pkg::ACT_MISSED
						|| act_q == vfh_pkg::ACT_FALSEBLK) && in_window && hit_det) begin
					mem_we    = 1'b1;
					mem_wdata = {want_allow ? vfh_pkg::OC_FN : vfh_pkg::OC_FP,
						e_verd, e_time, e_addr};
				end
			end
			default: begin
			end
		endcase
	end

	logic walking;
	assign walking = act_q == vfh_pkg::ACT_MARK || act_q == vfh_pkg::ACT_EVAL
		|| ((act_q == vfh_pkg::ACT_MISSED || act_q == vfh_pkg::ACT_FALSEBLK) && run_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= 16'd60;
			fblim_q  <= 16'd3277;
			malim_q  <= 16'd6554;
			step_q   <= 16'd3277;
		end else if (cfg_we) begin
			case (cfg_index)
				vfh_pkg::REG_WINDOW: window_q <= cfg_data;
				vfh_pkg::REG_FBLIM:  fblim_q  <= cfg_data;
				vfh_pkg::REG_MALIM:  malim_q  <= cfg_data;
				vfh_pkg::REG_STEP:   step_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_CUT;
					end
				end
				ST_CUT: begin
					if (act_q == vfh_pkg::ACT_RECORD) begin
						wp_q <= wp_q + 1'b1;
						if (fill_q != CW'(vfh_pkg::DEPTH)) begin
							fill_q <= fill_q + 1'b1;
						end
						state_q <= ST_DONE;
					end else if (walking && fill_q != '0) begin
						state_q <= ST_READ;
					end else begin
						state_q <= ST_RATE;
					end
				end
				ST_READ: state_q <= ST_CHECK;
				ST_CHECK: begin
					if ((act_q == vfh_pkg::ACT_MARK && hit_mark)
							|| (act_q != vfh_pkg::ACT_MARK && !in_window)
							|| idx_q + 1'b1 == fill_q) begin
						state_q <= ST_RATE;
					end else begin
						state_q <= ST_READ;
					end
				end
				ST_RATE: state_q <= ST_DONE;
				ST_DONE: state_q <= ST_OUT;
				ST_OUT: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	logic [1:0]  code_d;
	logic [16:0] da_d;
	logic [15:0] dr_d;
	logic [14:0] dd_d;
	logic        is_eval;
	assign is_eval = act_q == vfh_pkg::ACT_EVAL;

	always_comb begin
		code_d = vfh_pkg::ADJ_NONE;
		da_d   = '0;
		dr_d   = '0;
		dd_d   = '0;
		if (is_eval && classified >= vfh_pkg::MIN_CLASSIFIED) begin
			if ({5'd0, cnt_q.fp, 16'd0} > prod_fp_q) begin
				code_d = vfh_pkg::ADJ_RAISE;
				da_d   = {1'b0, step_q};
				dr_d   = {1'b0, step_q[15:1]};
				dd_d   = {1'b0, step_q[15:2]};
			end else if ({5'd0, cnt_q.fn, 16'd0} > prod_fn_q) begin
				code_d = vfh_pkg::ADJ_LOWER;
				da_d   = 17'd0 - {1'b0, step_q};
				dr_d   = 16'd0 - {1'b0, step_q[15:1]};
				dd_d   = 15'd0 - {1'b0, step_q[15:2]};
			end else begin
				code_d = vfh_pkg::ADJ_OK;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				act_q    <= s_tdata[2:0];
				addr_q   <= s_tdata[34:3];
				verd_q   <= s_tdata[36:35];
				oc_q     <= s_tdata[39:37];
				now_q    <= s_tdata[119:56];
				run_q    <= (s_tdata[2:0] == vfh_pkg::ACT_MISSED) ? (score_x10 >= 20'd458752)
					: (score_x10 <= 20'd131072);
				cut_q    <= s_tdata[119:56]
					- 64'(46'(window_q) * 46'(vfh_pkg::NS_PER_SEC));
				idx_q    <= '0;
				marked_q <= '0;
				cnt_q    <= '0;
				status_q <= s_tdata[2:0] == vfh_pkg::ACT_MARK;
			end
			ST_CUT: begin
				slot_q <= wp_q - 1'b1;
			end
			ST_CHECK: begin
				idx_q  <= idx_q + 1'b1;
				slot_q <= slot_q - 1'b1;
				if (act_q == vfh_pkg::ACT_MARK) begin
					if (hit_mark) status_q <= 1'b0;
				end else if (in_window) begin
					if (hit_det && act_q != vfh_pkg::ACT_EVAL) marked_q <= marked_q + 1'b1;
					if (is_eval) begin
						cnt_q.recs <= cnt_q.recs + 1'b1;
						case (e_oc)
							vfh_pkg::OC_TP: cnt_q.tp <= cnt_q.tp + 1'b1;
							vfh_pkg::OC_TN: cnt_q.tn <= cnt_q.tn + 1'b1;
							vfh_pkg::OC_FP: cnt_q.fp <= cnt_q.fp + 1'b1;
							vfh_pkg::OC_FN: cnt_q.fn <= cnt_q.fn + 1'b1;
							default: begin
							end
						endcase
					end
				end
			end
			ST_RATE: begin
				prod_fp_q <= 48'({16'd0, fblim_q} * 32'(cnt_q.fp + cnt_q.tn));
				prod_fn_q <= 48'({16'd0, malim_q} * 32'(cnt_q.fn + cnt_q.tp));
			end
			ST_OUT: begin
				if (!out_valid_q || m_tready) begin
					out_q <= {3'b0, dd_d, dr_d, da_d, code_d, cnt_q.fn, cnt_q.fp, cnt_q.tn,
						cnt_q.tp, cnt_q.recs, marked_q, status_q};
				end
			end
			default: begin
			end
		endcase
	end

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> state_q == ST_IDLE) else $error("ready outside idle");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(vfh_pkg::DEPTH)) else $error("fill level overrun");
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CHECK |-> idx_q < fill_q) else $error("walk past fill level");
	a_accept_go: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_CUT) else $error("request not started");

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for verdict_feedback_history_core. A queue-fed driver
// sends requests with random gaps, a monitor takes results under random
// back-pressure, and each accepted request is run through a local copy of the
// verdict ring to give the result that it must produce. Directed requests
// come first, then random traffic under several register settings, and last a
// long run of records and walks with no idling.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int GAP_LIMIT = 12000;
	localparam logic [63:0] NS = 64'd1000000000;

	typedef struct packed {
		logic [63:0] time_ns;
		logic [15:0] score;
		logic [2:0]  outcome;
		logic [1:0]  verdict;
		logic [31:0] source_address;
		logic [2:0]  action;
	} request_t;

	typedef struct packed {
		logic [2:0]  pad;
		logic [14:0] drop_step;
		logic [15:0] delta_rate;
		logic [16:0] delta_allow;
		logic [1:0]  adjust_code;
		logic [10:0] false_neg_count;
		logic [10:0] false_pos_count;
		logic [10:0] true_neg_count;
		logic [10:0] true_pos_count;
		logic [10:0] window_records;
		logic [10:0] marked_count;
		logic        status;
	} result_t;

	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready;
	logic [119:0] s_tdata, m_tdata;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;

	verdict_feedback_history_core dut (.*);

	// local copy of the ring
	logic [31:0] ring_addr[vfh_pkg::DEPTH];
	logic [63:0] ring_time[vfh_pkg::DEPTH];
	logic [1:0]  ring_verdict[vfh_pkg::DEPTH];
	logic [2:0]  ring_outcome[vfh_pkg::DEPTH];
	int ring_wp, ring_fill;
	logic [15:0] win_s, fb_limit, ma_limit, step;

	request_t pending_reqs[$];
	result_t  expected_results[$];
	logic [31:0] logged_addr[$];
	logic [63:0] logged_time[$];
	logic [31:0] addr_pool[6];
	logic [63:0] now_ns;
	int errors, quiet_cycles, s_gap, m_gap;
	bit quiet, s_took;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	task automatic report(string field, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("mismatch %s: got %0h expected %0h", field, got, want);
	endtask

	function automatic result_t verdict_walk(request_t r);
		result_t res;
		logic [63:0] cut;
		int s, tp, tn, fp, fn, recs, marked;
		res = '0;
		tp = 0; tn = 0; fp = 0; fn = 0; recs = 0; marked = 0;
		cut = r.time_ns - 64'(win_s) * NS;
		case (r.action)
			vfh_pkg::ACT_RECORD: begin
				ring_addr[ring_wp] = r.source_address;
				ring_time[ring_wp] = r.time_ns;
				ring_verdict[ring_wp] = r.verdict;
				ring_outcome[ring_wp] = vfh_pkg::OC_UNKNOWN;
				ring_wp = (ring_wp + 1) % vfh_pkg::DEPTH;
				if (ring_fill < vfh_pkg::DEPTH) ring_fill++;
			end
			vfh_pkg::ACT_MARK: begin
				res.status = 1'b1;
				for (int i = 0; i < ring_fill; i++) begin
					s = (ring_wp + vfh_pkg::DEPTH - 1 - i) % vfh_pkg::DEPTH;
					if (ring_addr[s] == r.source_address && ring_time[s] == r.time_ns) begin
						ring_outcome[s] = r.outcome;
						res.status = 1'b0;
						break;
					end
				end
			end
			vfh_pkg::ACT_MISSED, vfh_pkg::ACT_FALSEBLK: begin
				if ((r.action == vfh_pkg::ACT_MISSED && 32'(r.score) * 10 >= 32'd458752) ||
				    (r.action == vfh_pkg::ACT_FALSEBLK && 32'(r.score) * 10 <= 32'd131072))
				begin
					for (int i = 0; i < ring_fill; i++) begin
						s = (ring_wp + vfh_pkg::DEPTH - 1 - i) % vfh_pkg::DEPTH;
						if (ring_time[s] < cut) break;
						if (ring_addr[s] == r.source_address &&
						    ((ring_verdict[s] == 2'd0) == (r.action == vfh_pkg::ACT_MISSED)) &&
						    ring_outcome[s] == vfh_pkg::OC_UNKNOWN) begin
							ring_outcome[s] = (r.action == vfh_pkg::ACT_MISSED) ?
								vfh_pkg::OC_FN : vfh_pkg::OC_FP;
							marked++;
						end
					end
				end
				res.marked_count = 11'(marked);
			end
			vfh_pkg::ACT_EVAL: begin
				for (int i = 0; i < ring_fill; i++) begin
					s = (ring_wp + vfh_pkg::DEPTH - 1 - i) % vfh_pkg::DEPTH;
					if (ring_time[s] < cut) break;
					recs++;
					case (ring_outcome[s])
						vfh_pkg::OC_TP: tp++;
						vfh_pkg::OC_TN: tn++;
						vfh_pkg::OC_FP: fp++;
						vfh_pkg::OC_FN: fn++;
						default: ;
					endcase
				end
				res.window_records = 11'(recs);
				res.true_pos_count = 11'(tp);
				res.true_neg_count = 11'(tn);
				res.false_pos_count = 11'(fp);
				res.false_neg_count = 11'(fn);
				if (tp + tn + fp + fn >= 20) begin
					if (64'(fp) * 65536 > 64'(fb_limit) * 64'(fp + tn)) begin
						res.adjust_code = vfh_pkg::ADJ_RAISE;
						res.delta_allow = 17'(step);
						res.delta_rate = 16'(step >> 1);
						res.drop_step = 15'(step >> 2);
					end else if (64'(fn) * 65536 > 64'(ma_limit) * 64'(fn + tp)) begin
						res.adjust_code = vfh_pkg::ADJ_LOWER;
						res.delta_allow = 17'd0 - 17'(step);
						res.delta_rate = 16'd0 - 16'(step >> 1);
						res.drop_step = 15'd0 - 15'(step >> 2);
					end else begin
						res.adjust_code = vfh_pkg::ADJ_OK;
					end
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || s_took) begin
				if (!quiet && s_gap > 0) begin
					s_gap--;
					s_tvalid <= 1'b0;
				end else if (!quiet && $urandom_range(0, 11) == 0) begin
					s_gap = $urandom_range(0, 15);
					s_tvalid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					s_tdata <= pending_reqs.pop_front();
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			if (!quiet && m_gap > 0) begin
				m_gap--;
				m_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 11) == 0) begin
				m_gap = $urandom_range(0, 15);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		result_t got, want;
		s_took <= s_tvalid && s_tready;
		if (m_tvalid && m_tready) begin
			got = m_tdata;
			if (expected_results.size() == 0) begin
				report("unexpected result", m_tdata[63:0], 64'd0);
			end else begin
				want = expected_results.pop_front();
				if (got.status !== want.status)
					report("status", 64'(got.status), 64'(want.status));
				if (got.marked_count !== want.marked_count)
					report("marked_count", 64'(got.marked_count), 64'(want.marked_count));
				if (got.window_records !== want.window_records)
					report("window_records", 64'(got.window_records),
						64'(want.window_records));
				if (got.true_pos_count !== want.true_pos_count)
					report("true_pos_count", 64'(got.true_pos_count),
						64'(want.true_pos_count));
				if (got.true_neg_count !== want.true_neg_count)
					report("true_neg_count", 64'(got.true_neg_count),
						64'(want.true_neg_count));
				if (got.false_pos_count !== want.false_pos_count)
					report("false_pos_count", 64'(got.false_pos_count),
						64'(want.false_pos_count));
				if (got.false_neg_count !== want.false_neg_count)
					report("false_neg_count", 64'(got.false_neg_count),
						64'(want.false_neg_count));
				if (got.adjust_code !== want.adjust_code)
					report("adjust_code", 64'(got.adjust_code), 64'(want.adjust_code));
				if (got.delta_allow !== want.delta_allow)
					report("delta_allow", 64'(got.delta_allow), 64'(want.delta_allow));
				if (got.delta_rate !== want.delta_rate)
					report("delta_rate", 64'(got.delta_rate), 64'(want.delta_rate));
				if (got.drop_step !== want.drop_step)
					report("drop_step", 64'(got.drop_step), 64'(want.drop_step));
			end
		end
		if (s_tvalid && s_tready)
			expected_results.push_back(verdict_walk(request_t'(s_tdata)));
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n
				|| (pending_reqs.size() == 0 && expected_results.size() == 0 && !s_tvalid))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > GAP_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			vfh_pkg::REG_WINDOW: win_s = val;
			vfh_pkg::REG_FBLIM: fb_limit = val;
			vfh_pkg::REG_MALIM: ma_limit = val;
			default: step = val;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_regs(logic [15:0] w, logic [15:0] fb, logic [15:0] ma, logic [15:0] st);
		write_reg(vfh_pkg::REG_WINDOW, w);
		write_reg(vfh_pkg::REG_FBLIM, fb);
		write_reg(vfh_pkg::REG_MALIM, ma);
		write_reg(vfh_pkg::REG_STEP, st);
	endtask

	task automatic send(logic [2:0] act, logic [31:0] addr, logic [1:0] verd,
			logic [2:0] oc, logic [15:0] sc, logic [63:0] t);
		request_t r;
		r = '{time_ns: t, score: sc, outcome: oc, verdict: verd,
			source_address: addr, action: act};
		if (act == vfh_pkg::ACT_RECORD) begin
			logged_addr.push_back(addr);
			logged_time.push_back(t);
		end
		pending_reqs.push_back(r);
	endtask

	task automatic drain();
		do @(posedge clk);
		while (pending_reqs.size() > 0 || s_tvalid || expected_results.size() > 0);
	endtask

	task automatic random_request();
		int pick, k;
		logic [15:0] sc;
		logic [31:0] addr;
		logic [63:0] t;
		pick = $urandom_range(0, 99);
		addr = ($urandom_range(0, 9) == 0) ? $urandom : addr_pool[$urandom_range(0, 5)];
		if ($urandom_range(0, 19) == 0)
			now_ns += 64'($urandom_range(60, 200)) * NS;
		else
			now_ns += 64'($urandom_range(0, 2000000000));
		k = $urandom_range(0, 9);
		sc = (k < 5) ? 16'($urandom_range(45876, 65535)) :
			(k < 9) ? 16'($urandom_range(0, 13107)) : 16'($urandom);
		if (pick < 40) begin
			t = ($urandom_range(0, 9) == 0) ? now_ns - 64'($urandom_range(0, 90)) * NS : now_ns;
			send(vfh_pkg::ACT_RECORD, addr, 2'($urandom), 3'd0, 16'($urandom), t);
		end else if (pick < 60) begin
			if (logged_addr.size() > 0 && $urandom_range(0, 9) < 7) begin
				k = $urandom_range(0, logged_addr.size() - 1);
				send(vfh_pkg::ACT_MARK, logged_addr[k], 2'($urandom),
					3'($urandom_range(0, 7)), 16'($urandom), logged_time[k]);
			end else begin
				send(vfh_pkg::ACT_MARK, addr, 2'($urandom), 3'($urandom), 16'($urandom),
					{$urandom, $urandom});
			end
		end else if (pick < 72) begin
			send(vfh_pkg::ACT_MISSED, addr, 2'($urandom), 3'($urandom), sc, now_ns);
		end else if (pick < 84) begin
			send(vfh_pkg::ACT_FALSEBLK, addr, 2'($urandom), 3'($urandom), sc, now_ns);
		end else if (pick < 96) begin
			send(vfh_pkg::ACT_EVAL, addr, 2'($urandom), 3'($urandom), 16'($urandom), now_ns);
		end else begin
			send(3'($urandom_range(5, 7)), $urandom, 2'($urandom), 3'($urandom),
				16'($urandom), {$urandom, $urandom});
		end
	endtask

	initial begin
		logic [63:0] t0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = vfh_pkg::REG_WINDOW;
		cfg_data = '0;
		s_took = 1'b0;
		quiet = 1'b0;
		errors = 0;
		quiet_cycles = 0;
		s_gap = 0;
		m_gap = 0;
		ring_wp = 0;
		ring_fill = 0;
		win_s = 16'd60;
		fb_limit = 16'd3277;
		ma_limit = 16'd6554;
		step = 16'd3277;
		addr_pool = '{32'h0, 32'hFFFFFFFF, $urandom, $urandom, $urandom, $urandom};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed requests on reset settings
		t0 = 64'd1000 * NS;
		send(vfh_pkg::ACT_EVAL, 32'h0, 2'd0, 3'd0, 16'd0, t0);
		send(vfh_pkg::ACT_MARK, 32'h0, 2'd0, vfh_pkg::OC_TP, 16'd0, t0);
		send(vfh_pkg::ACT_MISSED, 32'h0, 2'd0, 3'd0, 16'hFFFF, t0);
		send(vfh_pkg::ACT_RECORD, 32'h0, 2'd0, 3'd0, 16'd0, t0);
		send(vfh_pkg::ACT_RECORD, 32'hFFFFFFFF, 2'd3, 3'd7, 16'hFFFF, t0 + 1);
		send(vfh_pkg::ACT_RECORD, 32'h0, 2'd1, 3'd0, 16'd0, t0 + 2);
		send(vfh_pkg::ACT_RECORD, 32'h0, 2'd0, 3'd0, 16'd0, t0);
		send(vfh_pkg::ACT_MARK, 32'h0, 2'd0, vfh_pkg::OC_TP, 16'd0, t0);
		send(vfh_pkg::ACT_MARK, 32'hFFFFFFFF, 2'd0, 3'd7, 16'd0, t0 + 1);
		send(vfh_pkg::ACT_MARK, 32'h1, 2'd0, vfh_pkg::OC_TN, 16'd0, t0);
		send(vfh_pkg::ACT_MISSED, 32'h0, 2'd0, 3'd0, 16'd45875, t0 + 5);
		send(vfh_pkg::ACT_MISSED, 32'h0, 2'd0, 3'd0, 16'd45876, t0 + 5);
		send(vfh_pkg::ACT_FALSEBLK, 32'h0, 2'd0, 3'd0, 16'd13108, t0 + 5);
		send(vfh_pkg::ACT_FALSEBLK, 32'h0, 2'd0, 3'd0, 16'd13107, t0 + 5);
		send(vfh_pkg::ACT_MISSED, 32'hFFFFFFFF, 2'd0, 3'd0, 16'hFFFF, t0 + 5);
		send(vfh_pkg::ACT_FALSEBLK, 32'hFFFFFFFF, 2'd0, 3'd0, 16'd0, t0 + 5);
		send(vfh_pkg::ACT_EVAL, 32'h0, 2'd0, 3'd0, 16'd0, t0 + 5);
		send(3'd7, 32'hFFFFFFFF, 2'd3, 3'd7, 16'hFFFF, 64'hFFFFFFFFFFFFFFFF);
		send(vfh_pkg::ACT_EVAL, 32'h0, 2'd0, 3'd0, 16'd0, 64'd0);
		send(vfh_pkg::ACT_EVAL, 32'h0, 2'd0, 3'd0, 16'd0, 64'hFFFFFFFFFFFFFFFF);
		drain();

		// random traffic under several settings
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: set_regs(16'd0, 16'd0, 16'd0, 16'hFFFF);
				1: set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
				2: set_regs(16'd60, 16'd3277, 16'd6554, 16'd3277);
				default: set_regs(16'($urandom_range(1, 300)), 16'($urandom),
					16'($urandom), 16'($urandom));
			endcase
			case (ph)
				1: now_ns = 64'($urandom_range(0, 30)) * NS;
				4: now_ns = 64'hFFFFFFFFFFFFFFFF - 64'd20 * NS;
				default: now_ns = {$urandom, $urandom};
			endcase
			for (int i = 0; i < 60; i++) random_request();
			drain();
		end

		// long run of records and walks, no idling
		quiet = 1'b1;
		set_regs(16'hFFFF, 16'($urandom), 16'($urandom), 16'($urandom));
		now_ns = {1'b0, 31'($urandom), $urandom};
		for (int i = 0; i < 120; i++) begin
			now_ns += 64'($urandom_range(0, 1000));
			send(vfh_pkg::ACT_RECORD, addr_pool[$urandom_range(0, 5)], 2'($urandom), 3'd0,
				16'($urandom), now_ns);
		end
		send(vfh_pkg::ACT_MISSED, addr_pool[0], 2'd0, 3'd0, 16'hFFFF, now_ns);
		send(vfh_pkg::ACT_FALSEBLK, addr_pool[1], 2'd0, 3'd0, 16'd0, now_ns);
		send(vfh_pkg::ACT_EVAL, 32'h0, 2'd0, 3'd0, 16'd0, now_ns);
		for (int i = 0; i < 17; i++) random_request();
		drain();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
